FILE: rtl/tcw_pkg.sv
// Shared types and constants for the text console writer.
package tcw_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
        logic [4:0] read_row;
        logic [6:0] read_col;
    } t_in;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
    } t_out;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_SCROLL
    } t_state;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic clr_write;
        logic update;
        logic scroll_step;
        logic cnt_rst;
        logic set_pend;
        logic emit;
    } t_ctl_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic pend;
        logic out_free;
        logic scroll_req;
        logic cnt_last;
        logic cnt_end;
    } t_dp_status;

    localparam logic        KIND_PUT     = 1'b0;
    localparam logic        KIND_READ    = 1'b1;
    localparam logic [15:0] RESET_CELL   = 16'h0720;
    localparam logic [15:0] ATTR_MASK    = 16'hFF00;
    localparam logic [7:0]  BLANK_GLYPH  = 8'h20;
    localparam logic [7:0]  CH_NEWLINE   = 8'd10;
    localparam logic [7:0]  CH_BACKSPACE = 8'd8;

endpackage

FILE: rtl/tcw_ram.sv
// Generic simple dual-port RAM with registered read.
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/tcw_ctrl.sv
// Controller state machine: clearing pass, item handshake, update and scroll.
module tcw_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcw_pkg::t_dp_status i_status,
    output tcw_pkg::t_ctl_cmd   o_cmd
);
    import tcw_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_write = 1'b1;
                if (i_status.cnt_last) begin
                    o_cmd.cnt_rst = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_IDLE: begin
                // release a finished result and take the next beat together
                o_cmd.emit   = i_status.pend && i_status.out_free;
                o_in_ready   = !i_status.pend || i_status.out_free;
                o_cmd.accept = i_in_valid && o_in_ready;
                if (o_cmd.accept) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                if (i_status.scroll_req) begin
                    n_state = ST_SCROLL;
                end else begin
                    o_cmd.set_pend = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            ST_SCROLL: begin
                o_cmd.scroll_step = 1'b1;
                if (i_status.cnt_end) begin
                    o_cmd.cnt_rst  = 1'b1;
                    o_cmd.set_pend = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end
endmodule

FILE: rtl/tcw_datapath.sv
// Datapath: cursor, screen buffer, sweep counter and result register.
module tcw_datapath #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int SCROLL_ROW = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  tcw_pkg::t_ctl_cmd   i_cmd,
    output tcw_pkg::t_dp_status o_status,
    input  tcw_pkg::t_in        i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcw_pkg::t_out       o_out_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CNTW       = $clog2(CELL_COUNT + 1);
    localparam int CW         = $clog2(COLUMNS + 1);
    localparam int RW         = $clog2(SCROLL_ROW + 1);

    logic [CW-1:0]   r_col;
    logic [RW-1:0]   r_row;
    logic            r_kind;
    logic [7:0]      r_char;
    logic [AW-1:0]   r_addr;
    logic            r_exists;
    logic [15:0]     r_cell;
    logic            r_pend;
    logic            r_ovalid;
    t_out            r_out;
    logic [CNTW-1:0] r_cnt;

    // access address for a new beat
    logic [CW-1:0] tgt_col;
    logic [31:0]   acc_row;
    logic [31:0]   acc_col;
    logic [31:0]   acc_addr;
    logic          acc_exists;

    // cursor update
    logic          is_nl;
    logic          is_bs;
    logic [CW-1:0] col_a;
    logic [RW-1:0] row_a;
    logic [RW-1:0] row_b;
    logic          do_wr;
    logic [7:0]    glyph;
    logic          scroll_req;

    // sweep addressing
    logic [CNTW-1:0] wcnt;
    logic [31:0]     src_full;
    logic            wr_last_row;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [15:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [15:0]   ram_rdata;

    always_comb begin
        tgt_col = r_col;
        if (i_in_data.char_code == CH_BACKSPACE && r_col != '0) begin
            tgt_col = r_col - 1'b1;
        end
        if (i_in_data.kind == KIND_READ) begin
            acc_row    = 32'(i_in_data.read_row);
            acc_col    = 32'(i_in_data.read_col);
            acc_exists = (acc_row < ROWS) && (acc_col < COLUMNS);
        end else begin
            acc_row    = 32'(r_row);
            acc_col    = 32'(tgt_col);
            acc_exists = (acc_row < ROWS);
        end
        acc_addr = acc_row * COLUMNS + acc_col;
    end

    always_comb begin
        is_nl = (r_char == CH_NEWLINE);
        is_bs = (r_char == CH_BACKSPACE);
        col_a = r_col;
        row_a = r_row;
        do_wr = 1'b0;
        glyph = r_char;
        if (is_nl) begin
            col_a = '0;
            row_a = r_row + 1'b1;
        end else if (is_bs) begin
            glyph = BLANK_GLYPH;
            if (r_col != '0) begin
                col_a = r_col - 1'b1;
                do_wr = r_exists;
            end
        end else begin
            col_a = r_col + 1'b1;
            do_wr = r_exists;
        end
        if (32'(col_a) >= COLUMNS) begin
            col_a = '0;
            row_a = row_a + 1'b1;
        end
        scroll_req = (r_kind == KIND_PUT) && (32'(row_a) >= SCROLL_ROW);
        row_b      = scroll_req ? row_a - 1'b1 : row_a;
    end

    always_comb begin
        wcnt        = r_cnt - 1'b1;
        wr_last_row = (32'(wcnt) >= LAST_BASE);
        if (32'(r_cnt) < LAST_BASE) begin
            src_full = 32'(r_cnt) + COLUMNS;
        end else begin
            src_full = 32'(r_cnt);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_addr;
        ram_wdata = {ram_rdata[15:8], glyph};
        ram_re    = 1'b0;
        ram_raddr = acc_addr[AW-1:0];
        if (i_cmd.clr_write) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt[AW-1:0];
            ram_wdata = RESET_CELL;
        end else if (i_cmd.update) begin
            ram_we = (r_kind == KIND_PUT) && do_wr;
        end else if (i_cmd.scroll_step) begin
            // read one cell ahead, write the one read last cycle
            ram_we    = (r_cnt != '0);
            ram_waddr = wcnt[AW-1:0];
            ram_wdata = wr_last_row ? ((ram_rdata & ATTR_MASK) | {8'h00, BLANK_GLYPH})
                                    : ram_rdata;
            ram_re    = (32'(r_cnt) < CELL_COUNT);
            ram_raddr = src_full[AW-1:0];
        end else if (i_cmd.accept) begin
            ram_re = 1'b1;
        end
    end

    tcw_ram #(
        .WIDTH(16),
        .DEPTH(CELL_COUNT)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
        end else begin
            if (i_cmd.update && r_kind == KIND_PUT) begin
                r_col <= col_a;
                r_row <= row_b;
            end
            if (i_cmd.set_pend) begin
                r_pend <= 1'b1;
            end else if (i_cmd.emit) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.emit) begin
                r_ovalid <= 1'b1;
            end else if (i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.cnt_rst) begin
                r_cnt <= '0;
            end else if (i_cmd.clr_write || i_cmd.scroll_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_kind   <= i_in_data.kind;
            r_char   <= i_in_data.char_code;
            r_addr   <= acc_addr[AW-1:0];
            r_exists <= acc_exists;
        end
        if (i_cmd.update) begin
            r_cell <= (r_kind == KIND_READ && r_exists) ? ram_rdata : 16'h0000;
        end
        if (i_cmd.emit) begin
            r_out.cell_data  <= r_cell;
            r_out.cursor_col <= 7'(r_col);
            r_out.cursor_row <= 5'(r_row);
        end
    end

    assign o_status.pend       = r_pend;
    assign o_status.out_free   = !r_ovalid || i_out_ready;
    assign o_status.scroll_req = scroll_req;
    assign o_status.cnt_last   = (32'(r_cnt) == CELL_COUNT - 1);
    assign o_status.cnt_end    = (32'(r_cnt) == CELL_COUNT);

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
endmodule

FILE: rtl/text_console_writer_core.sv
// Top level of the text console writer: controller plus datapath.
//
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_ready   | kind, char_code, read_row, read_col
//  out     | output    | o_out_valid / i_out_ready | cell_data, cursor_col, cursor_row
//
// The cell is read from the screen RAM on acceptance and, for a put, written back
// (read-modify-write) in the next cycle, through the single RAM port pair.
// A put that scrolls adds a row copy through the same RAM.
// After reset a clearing pass fills the buffer; o_in_ready is low.
// A stalled output holds its beat; the next item is taken while one result waits.
module text_console_writer_core #(
    parameter int COLUMNS    = 80,
    parameter int ROWS       = 25,
    parameter int SCROLL_ROW = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  tcw_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output tcw_pkg::t_out o_out_data
);
    import tcw_pkg::*;

    t_ctl_cmd   cmd;
    t_dp_status status;

    tcw_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    tcw_datapath #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .SCROLL_ROW(SCROLL_ROW)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );
endmodule

FILE: rtl/tcw_checker.sv
// Port-level checker for the text console writer, bound to the top level.
module tcw_checker #(
    parameter int COLUMNS = 80
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input tcw_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input tcw_pkg::t_out o_out_data
);
    import tcw_pkg::*;

    // a result beat holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output beat dropped or changed while stalled");

    // reset starts the clearing pass with nothing offered
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("ready or valid high straight after reset");

    // reported column is always inside the row
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_out_data.cursor_col) < COLUMNS))
        else $error("cursor column outside the row");

    // no new beat can follow acceptance in the very next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken while the previous beat is in update");
endmodule

bind text_console_writer_core tcw_checker #(
    .COLUMNS(COLUMNS)
) u_tcw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .i_in_data  (i_in_data),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_out_data (o_out_data)
);
